[src/cpt_pkg.sv]
// widths, codes and stage record types for the closest point on triangle pipeline
// no dependencies; imported by the top level

package cpt_pkg;

    localparam int CW       = 32;                     // coordinate width
    localparam int IN_W     = ((12 * CW + 7) / 8) * 8;
    localparam int OUT_W    = ((3 * CW + 7) / 8) * 8;
    localparam int REGION_W = 3;

    localparam int DW   = CW + 1;                     // vertex difference
    localparam int PW   = 2 * DW;                     // difference product
    localparam int DOTW = PW + 2;                     // dot product d1..d6
    localparam int EW   = DOTW + 1;                   // d4-d3, d5-d6
    localparam int HL   = DOTW / 2;                   // low half of a dot magnitude
    localparam int HH   = DOTW - HL;                  // high half
    localparam int XW   = 2 * DOTW;                   // cross term magnitude
    localparam int VW   = XW + 1;                     // va, vb, vc
    localparam int DENW = VW + 2;                     // scale and denominator
    localparam int LB   = 32;                         // limb width of the scale multiply
    localparam int NLB  = (DENW + LB - 1) / LB;
    localparam int SPW  = NLB * LB;
    localparam int NPW  = DENW + DW;                  // numerator term magnitude
    localparam int NW   = NPW + 2;                    // signed numerator
    localparam int TW   = NW + 2;                     // 2*numer + den
    localparam int RW   = TW;                         // divider remainder
    localparam int DDW  = DENW + 1;                   // 2*den
    localparam int QB   = CW + 2;                     // quotient bits before saturation

    typedef enum logic [REGION_W-1:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_AB = 3'd2,
        REG_C  = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } region_t;

    typedef struct packed {
        logic [2:0][DW-1:0] ab;
        logic [2:0][DW-1:0] ac;
        logic [2:0][DW-1:0] cb;
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0][CW-1:0] c;
    } geo_t;

    typedef struct packed {
        logic [5:0][DOTW-1:0] d;
        logic [EW-1:0]        e43;
        logic [EW-1:0]        e56;
    } dot_t;

    typedef struct packed {
        region_t            region;
        logic               dz;
        logic [2:0][CW-1:0] base;
    } side_t;

    typedef struct packed {
        logic [2:0][RW-1:0] r;
        logic [DDW-1:0]     dd;
        logic [2:0][QB-1:0] q;
        logic [2:0]         tneg;
        logic [2:0]         ovf;
        side_t              side;
    } div_t;

endpackage

[src/closest_point_on_triangle.sv]
// closest point on a triangle by voronoi region, fully pipelined fixed point
// depends on cpt_pkg
//
// usage: one transaction on s_axis carries the query point and the three
// vertices, one transaction on m_axis returns the nearest point (tdata) and
// the region code (tuser). items are independent and one may enter in every
// clock cycle, so throughput is one item per cycle while m_axis_tready is high.
// the delay from input transaction to m_axis_tvalid is set by the dot and cross
// product stages, the region decision, the numerator build and the restoring
// divider, which retires one quotient bit per stage (QB stages).
// the last pipeline stage and the output register form a skid pair: while a
// result waits on a low m_axis_tready, the pipeline keeps taking input until
// its last stage is full, then the whole pipeline holds; nothing is lost or
// repeated. rst_n clears all valid bits, including the output valid; payload
// registers are not reset. a degenerate edge returns the edge start point and
// a degenerate interior returns vertex A; results saturate to the coordinate
// range.

module closest_point_on_triangle
    import cpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
    // vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // near_x, near_y, near_z
    output logic [OUT_W-1:0]    m_axis_tdata,
    // region
    output logic [REGION_W-1:0] m_axis_tuser
);

    localparam int NST = QB + 17;
    localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

    function automatic logic [DW-1:0] dif(input logic [CW-1:0] x, input logic [CW-1:0] y);
        dif = {x[CW-1], x} - {y[CW-1], y};
    endfunction

    function automatic logic signed [VW-1:0] sv(input logic [XW-1:0] m, input logic n);
        logic signed [VW-1:0] v;
        v  = $signed({1'b0, m});
        sv = n ? -v : v;
    endfunction

    function automatic logic signed [NW-1:0] sn(input logic [NPW-1:0] m, input logic n);
        logic signed [NW-1:0] v;
        v  = NW'($signed({1'b0, m}));
        sn = n ? -v : v;
    endfunction

    logic               en;
    logic [NST-1:0]     vld_reg;
    logic               ov_reg;
    logic               o_load;

    geo_t               geo_reg [1:7];
    logic [2:0][DW-1:0] ap1_reg, bp1_reg, cp1_reg;
    logic signed [PW-1:0]   pr2_reg [6][3];
    logic signed [DOTW-1:0] d3_reg [6];
    dot_t               dot_reg [4:7];
    logic [5:0][DOTW-1:0] dm4_reg;
    logic [5:0]         dn4_reg;
    logic [2*HH-1:0]    pp5_reg [6][4];
    logic [5:0]         xn5_reg, xn6_reg;
    logic [XW-1:0]      pm6_reg [6];
    logic signed [VW-1:0] va7_reg, vb7_reg, vc7_reg;

    logic signed [DOTW-1:0] c8_d [6];
    logic signed [EW-1:0]   c8_e43, c8_e56;
    logic signed [DENW-1:0] c8_s1, c8_s2, c8_den;
    logic [2:0][DW-1:0]     c8_v1, c8_v2;
    side_t                  c8_side;

    logic signed [DENW-1:0] s8_s1_reg, s8_s2_reg, s8_den_reg;
    logic [2:0][DW-1:0]     s8_v1_reg, s8_v2_reg;
    side_t                  side_reg [8:14];

    logic [1:0][DENW-1:0]   s9_sm_reg;
    logic [1:0][2:0][DW-1:0] s9_vm_reg;
    logic [1:0][2:0]        sg_reg [9:11];
    logic [DENW-1:0]        dabs_reg [9:14];
    logic [1:0][SPW-1:0]    sp9;

    logic [LB+DW-1:0]       pp10_reg [2][3][NLB];
    logic [NPW-1:0]         p11_next [2][3];
    logic [NPW-1:0]         p11_reg [2][3];
    logic signed [NW-1:0]   n12_reg [3];
    logic signed [TW-1:0]   t13_reg [3];
    logic [2:0][TW-1:0]     tm14_reg;
    logic [2:0]             tn14_reg;

    div_t                   div_reg [QB+1];

    logic signed [QB:0]     f1_q_reg [3];
    logic [2:0]             f1_ovf_reg;
    side_t                  f1_side_reg;
    logic [2:0][CW-1:0]     f2_next;
    logic [2:0][CW-1:0]     f2_near_reg;
    region_t                f2_region_reg;
    logic [2:0][CW-1:0]     o_near_reg;
    region_t                o_region_reg;

    // last stage moves on when empty or when the output register can take it
    assign en            = !vld_reg[NST-1] || !ov_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign o_load        = vld_reg[NST-1] && (!ov_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
            end
            if (o_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // differences, products, dot products, cross terms and va, vb, vc
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                geo_reg[1].ab[k] <= dif(s_axis_tdata[(6+k)*CW +: CW], s_axis_tdata[(3+k)*CW +: CW]);
                geo_reg[1].ac[k] <= dif(s_axis_tdata[(9+k)*CW +: CW], s_axis_tdata[(3+k)*CW +: CW]);
                geo_reg[1].cb[k] <= dif(s_axis_tdata[(9+k)*CW +: CW], s_axis_tdata[(6+k)*CW +: CW]);
                geo_reg[1].a[k]  <= s_axis_tdata[(3+k)*CW +: CW];
                geo_reg[1].b[k]  <= s_axis_tdata[(6+k)*CW +: CW];
                geo_reg[1].c[k]  <= s_axis_tdata[(9+k)*CW +: CW];
                ap1_reg[k] <= dif(s_axis_tdata[k*CW +: CW], s_axis_tdata[(3+k)*CW +: CW]);
                bp1_reg[k] <= dif(s_axis_tdata[k*CW +: CW], s_axis_tdata[(6+k)*CW +: CW]);
                cp1_reg[k] <= dif(s_axis_tdata[k*CW +: CW], s_axis_tdata[(9+k)*CW +: CW]);
            end
            for (int s = 2; s <= 7; s++)
            begin
                geo_reg[s] <= geo_reg[s-1];
            end

            for (int k = 0; k < 3; k++)
            begin
                pr2_reg[0][k] <= $signed(geo_reg[1].ab[k]) * $signed(ap1_reg[k]);
                pr2_reg[1][k] <= $signed(geo_reg[1].ac[k]) * $signed(ap1_reg[k]);
                pr2_reg[2][k] <= $signed(geo_reg[1].ab[k]) * $signed(bp1_reg[k]);
                pr2_reg[3][k] <= $signed(geo_reg[1].ac[k]) * $signed(bp1_reg[k]);
                pr2_reg[4][k] <= $signed(geo_reg[1].ab[k]) * $signed(cp1_reg[k]);
                pr2_reg[5][k] <= $signed(geo_reg[1].ac[k]) * $signed(cp1_reg[k]);
            end

            for (int j = 0; j < 6; j++)
            begin
                d3_reg[j] <= DOTW'(pr2_reg[j][0]) + DOTW'(pr2_reg[j][1]) + DOTW'(pr2_reg[j][2]);
            end

            for (int j = 0; j < 6; j++)
            begin
                dot_reg[4].d[j] <= d3_reg[j];
                dm4_reg[j]      <= d3_reg[j][DOTW-1] ? DOTW'(-d3_reg[j]) : DOTW'(d3_reg[j]);
                dn4_reg[j]      <= d3_reg[j][DOTW-1];
            end
            dot_reg[4].e43 <= EW'(d3_reg[3]) - EW'(d3_reg[2]);
            dot_reg[4].e56 <= EW'(d3_reg[4]) - EW'(d3_reg[5]);
            for (int s = 5; s <= 7; s++)
            begin
                dot_reg[s] <= dot_reg[s-1];
            end

            // cross terms as four half-width partial products each
            for (int j = 0; j < 6; j++)
            begin
                pp5_reg[j][0] <= (2*HH)'(dm4_reg[PX[j]][HL-1:0]) * (2*HH)'(dm4_reg[PY[j]][HL-1:0]);
                pp5_reg[j][1] <= (2*HH)'(dm4_reg[PX[j]][HL-1:0]) * (2*HH)'(dm4_reg[PY[j]][DOTW-1:HL]);
                pp5_reg[j][2] <= (2*HH)'(dm4_reg[PX[j]][DOTW-1:HL]) * (2*HH)'(dm4_reg[PY[j]][HL-1:0]);
                pp5_reg[j][3] <= (2*HH)'(dm4_reg[PX[j]][DOTW-1:HL]) * (2*HH)'(dm4_reg[PY[j]][DOTW-1:HL]);
                xn5_reg[j]    <= dn4_reg[PX[j]] ^ dn4_reg[PY[j]];
            end

            for (int j = 0; j < 6; j++)
            begin
                pm6_reg[j] <= (XW'(pp5_reg[j][3]) << (2*HL))
                            + ((XW'(pp5_reg[j][1]) + XW'(pp5_reg[j][2])) << HL)
                            + XW'(pp5_reg[j][0]);
            end
            xn6_reg <= xn5_reg;

            vc7_reg <= sv(pm6_reg[0], xn6_reg[0]) - sv(pm6_reg[1], xn6_reg[1]);
            vb7_reg <= sv(pm6_reg[2], xn6_reg[2]) - sv(pm6_reg[3], xn6_reg[3]);
            va7_reg <= sv(pm6_reg[4], xn6_reg[4]) - sv(pm6_reg[5], xn6_reg[5]);
        end
    end

    // region decision, first test that holds wins
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            c8_d[j] = $signed(dot_reg[7].d[j]);
        end
        c8_e43 = $signed(dot_reg[7].e43);
        c8_e56 = $signed(dot_reg[7].e56);
        c8_s1  = '0;
        c8_s2  = '0;
        c8_den = '0;
        c8_v1  = geo_reg[7].ab;
        c8_v2  = geo_reg[7].ac;
        c8_side.base   = geo_reg[7].a;
        c8_side.region = REG_IN;
        if (c8_d[0] <= 0 && c8_d[1] <= 0)
        begin
            c8_side.region = REG_A;
        end
        else if (c8_d[2] >= 0 && c8_e43 <= 0)
        begin
            c8_side.region = REG_B;
            c8_side.base   = geo_reg[7].b;
        end
        else if (vc7_reg <= 0 && c8_d[0] >= 0 && c8_d[2] <= 0)
        begin
            c8_side.region = REG_AB;
            c8_s1  = DENW'(c8_d[0]);
            c8_den = DENW'(c8_d[0]) - DENW'(c8_d[2]);
        end
        else if (c8_d[5] >= 0 && c8_e56 <= 0)
        begin
            c8_side.region = REG_C;
            c8_side.base   = geo_reg[7].c;
        end
        else if (vb7_reg <= 0 && c8_d[1] >= 0 && c8_d[5] <= 0)
        begin
            c8_side.region = REG_AC;
            c8_s1  = DENW'(c8_d[1]);
            c8_v1  = geo_reg[7].ac;
            c8_den = DENW'(c8_d[1]) - DENW'(c8_d[5]);
        end
        else if (va7_reg <= 0 && c8_e43 >= 0 && c8_e56 >= 0)
        begin
            c8_side.region = REG_BC;
            c8_side.base   = geo_reg[7].b;
            c8_s1  = DENW'(c8_e43);
            c8_v1  = geo_reg[7].cb;
            c8_den = DENW'(c8_e43) + DENW'(c8_e56);
        end
        else
        begin
            c8_s1  = DENW'(vb7_reg);
            c8_s2  = DENW'(vc7_reg);
            c8_den = DENW'(va7_reg) + DENW'(vb7_reg) + DENW'(vc7_reg);
        end
        c8_side.dz = (c8_den == 0);
    end

    assign sp9[0] = SPW'(s9_sm_reg[0]);
    assign sp9[1] = SPW'(s9_sm_reg[1]);

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p11_next[t][k] = '0;
                for (int l = 0; l < NLB; l++)
                begin
                    p11_next[t][k] = p11_next[t][k]
                                   + NPW'((SPW+DW)'(pp10_reg[t][k][l]) << (l*LB));
                end
            end
        end
    end

    // numerator build and sign normalization
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_s1_reg   <= c8_s1;
            s8_s2_reg   <= c8_s2;
            s8_den_reg  <= c8_den;
            s8_v1_reg   <= c8_v1;
            s8_v2_reg   <= c8_v2;
            side_reg[8] <= c8_side;
            for (int s = 9; s <= 14; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end

            s9_sm_reg[0] <= s8_s1_reg[DENW-1] ? DENW'(-s8_s1_reg) : DENW'(s8_s1_reg);
            s9_sm_reg[1] <= s8_s2_reg[DENW-1] ? DENW'(-s8_s2_reg) : DENW'(s8_s2_reg);
            dabs_reg[9]  <= s8_den_reg[DENW-1] ? DENW'(-s8_den_reg) : DENW'(s8_den_reg);
            for (int k = 0; k < 3; k++)
            begin
                s9_vm_reg[0][k] <= s8_v1_reg[k][DW-1] ? -s8_v1_reg[k] : s8_v1_reg[k];
                s9_vm_reg[1][k] <= s8_v2_reg[k][DW-1] ? -s8_v2_reg[k] : s8_v2_reg[k];
                sg_reg[9][0][k] <= s8_s1_reg[DENW-1] ^ s8_v1_reg[k][DW-1] ^ s8_den_reg[DENW-1];
                sg_reg[9][1][k] <= s8_s2_reg[DENW-1] ^ s8_v2_reg[k][DW-1] ^ s8_den_reg[DENW-1];
            end
            for (int s = 10; s <= 14; s++)
            begin
                dabs_reg[s] <= dabs_reg[s-1];
            end
            for (int s = 10; s <= 11; s++)
            begin
                sg_reg[s] <= sg_reg[s-1];
            end

            for (int t = 0; t < 2; t++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    for (int l = 0; l < NLB; l++)
                    begin
                        pp10_reg[t][k][l] <= (LB+DW)'(sp9[t][l*LB +: LB])
                                           * (LB+DW)'(s9_vm_reg[t][k]);
                    end
                end
            end

            p11_reg <= p11_next;

            for (int k = 0; k < 3; k++)
            begin
                n12_reg[k] <= sn(p11_reg[0][k], sg_reg[11][0][k])
                            + sn(p11_reg[1][k], sg_reg[11][1][k]);
                t13_reg[k] <= (TW'(n12_reg[k]) <<< 1) + TW'($signed({1'b0, dabs_reg[12]}));
                tm14_reg[k] <= t13_reg[k][TW-1] ? TW'(-t13_reg[k]) : TW'(t13_reg[k]);
                tn14_reg[k] <= t13_reg[k][TW-1];
            end

            // divider entry: quotient beyond QB bits saturates anyway
            for (int k = 0; k < 3; k++)
            begin
                div_reg[0].r[k]   <= tm14_reg[k];
                div_reg[0].ovf[k] <= tm14_reg[k] >= (RW'({dabs_reg[14], 1'b0}) << QB);
            end
            div_reg[0].dd   <= {dabs_reg[14], 1'b0};
            div_reg[0].q    <= '0;
            div_reg[0].tneg <= tn14_reg;
            div_reg[0].side <= side_reg[14];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 1; i <= QB; i++)
    begin : g_div
        localparam int BIT = QB - i;
        div_t div_next;

        always_comb
        begin
            div_next = div_reg[i-1];
            for (int k = 0; k < 3; k++)
            begin
                if (div_reg[i-1].r[k] >= (RW'(div_reg[i-1].dd) << BIT))
                begin
                    div_next.r[k]      = div_reg[i-1].r[k] - (RW'(div_reg[i-1].dd) << BIT);
                    div_next.q[k][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[i] <= div_next;
            end
        end
    end

    // base plus rounded quotient, then clamp
    always_comb
    begin
        logic signed [CW+3:0] sum;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            sum = (CW+4)'($signed(f1_side_reg.base[k])) + (CW+4)'(f1_q_reg[k]);
            if (f1_side_reg.dz)
            begin
                f2_next[k] = f1_side_reg.base[k];
            end
            else if (f1_ovf_reg[k] || (sum[CW+3:CW-1] != {5{sum[CW-1]}}))
            begin
                f2_next[k] = (f1_ovf_reg[k] ? f1_q_reg[k][QB] : sum[CW+3])
                           ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end
            else
            begin
                f2_next[k] = sum[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                // floor for negative dividend: quotient plus one when remainder left
                f1_q_reg[k] <= div_reg[QB].tneg[k]
                             ? -({1'b0, div_reg[QB].q[k]} + (QB+1)'(|div_reg[QB].r[k]))
                             : {1'b0, div_reg[QB].q[k]};
            end
            f1_ovf_reg    <= div_reg[QB].ovf;
            f1_side_reg   <= div_reg[QB].side;
            f2_near_reg   <= f2_next;
            f2_region_reg <= f1_side_reg.region;
        end
        if (o_load)
        begin
            o_near_reg   <= f2_near_reg;
            o_region_reg <= f2_region_reg;
        end
    end

    always_comb
    begin
        m_axis_tdata = '0;
        for (int k = 0; k < 3; k++)
        begin
            m_axis_tdata[k*CW +: CW] = o_near_reg[k];
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = o_region_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NST-1] |-> s_axis_tready)
        else $error("input blocked while last stage is empty");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_axis_tready && vld_reg[NST-1] |-> !s_axis_tready)
        else $error("input taken while both output registers are full");

    a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-1] && !s_axis_tready |=> vld_reg[NST-1])
        else $error("stalled result dropped from last stage");

endmodule
